[src/alle_pkg.sv]
// Shared codes, field widths and defaults for the array linked list engine.
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

   // Fixed widths of the request and response fields
   localparam int OPCODE_W   = 2;
   localparam int KEY_W      = 32;
   localparam int SLOT_IDX_W = 4;
   localparam int STATUS_W   = 2;

   // Default number of slots
   localparam int DEF_SLOT_COUNT = 16;

   // Request operations
   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2
   } opcode_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

endpackage

`default_nettype wire

[src/array_linked_list_engine.sv]
// Top level of the array linked list engine: controller and slot memories.
//
//   channel  direction  ports                                       transfer when
//   req      in         req_opcode, req_key_value, req_slot_index   req_valid & req_ready
//   rsp      out        rsp_status, rsp_result_slot                 rsp_valid & rsp_ready
//
// One item at a time. Insert passes S_INS, then S_INS_LINK if the list was not empty; delete
// passes S_DEL_CHK, then S_DEL_LINK for a slot in use; search visits up to SLOT_COUNT slots.
// Unused opcodes, full inserts, empty-list searches and out-of-range deletes skip to S_REPLY.
// After reset a pass over every slot builds the free chain; req_ready stays low meanwhile.
// A waiting response is held in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_engine #(
   parameter int SLOT_COUNT = alle_pkg::DEF_SLOT_COUNT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [alle_pkg::OPCODE_W-1:0]           req_opcode,
   input  wire logic signed [alle_pkg::KEY_W-1:0]       req_key_value,
   input  wire logic [alle_pkg::SLOT_IDX_W-1:0]         req_slot_index,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [alle_pkg::STATUS_W-1:0]                rsp_status,
   output logic [alle_pkg::SLOT_IDX_W-1:0]              rsp_result_slot
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int LW = SW + 1;
   localparam int KW = alle_pkg::KEY_W;

   logic              a_wr_en, a_rd_en, b_wr_en, b_rd_en;
   logic [SW-1:0]     a_wr_addr, a_rd_addr, b_wr_addr, b_rd_addr;
   logic [LW:0]       a_wr_data, a_rd_data;
   logic [KW+LW-1:0]  b_wr_data, b_rd_data;

   // Sequencer
   alle_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_key_value   (req_key_value),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot),
      .a_wr_en         (a_wr_en),
      .a_wr_addr       (a_wr_addr),
      .a_wr_data       (a_wr_data),
      .a_rd_en         (a_rd_en),
      .a_rd_addr       (a_rd_addr),
      .a_rd_data       (a_rd_data),
      .b_wr_en         (b_wr_en),
      .b_wr_addr       (b_wr_addr),
      .b_wr_data       (b_wr_data),
      .b_rd_en         (b_rd_en),
      .b_rd_addr       (b_rd_addr),
      .b_rd_data       (b_rd_data)
   );

   // Link memory: {in_use, next}
   alle_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (LW + 1)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   // Node memory: {key, prev}
   alle_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (KW + LW)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

endmodule

`default_nettype wire

[src/alle_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module alle_ram #(
   parameter int DEPTH = alle_pkg::DEF_SLOT_COUNT,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port: data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/alle_ctrl.sv]
// Sequencer for insert, delete and search over the link and node memories.
`timescale 1ns / 1ps
`default_nettype none

module alle_ctrl #(
   parameter int SLOT_COUNT = alle_pkg::DEF_SLOT_COUNT,
   localparam int SW = $clog2(SLOT_COUNT),
   localparam int LW = SW + 1,
   localparam int KW = alle_pkg::KEY_W
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [alle_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic signed [KW-1:0]              req_key_value,
   input  wire logic [alle_pkg::SLOT_IDX_W-1:0]   req_slot_index,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [alle_pkg::STATUS_W-1:0]          rsp_status,
   output logic [alle_pkg::SLOT_IDX_W-1:0]        rsp_result_slot,
   // link memory: {in_use, next}
   output logic                                   a_wr_en,
   output logic [SW-1:0]                          a_wr_addr,
   output logic [LW:0]                            a_wr_data,
   output logic                                   a_rd_en,
   output logic [SW-1:0]                          a_rd_addr,
   input  wire logic [LW:0]                       a_rd_data,
   // node memory: {key, prev}
   output logic                                   b_wr_en,
   output logic [SW-1:0]                          b_wr_addr,
   output logic [KW+LW-1:0]                       b_wr_data,
   output logic                                   b_rd_en,
   output logic [SW-1:0]                          b_rd_addr,
   input  wire logic [KW+LW-1:0]                  b_rd_data
);

   localparam int          RSW  = alle_pkg::SLOT_IDX_W;
   localparam logic [LW-1:0] NIL = '1;

   typedef enum logic [7:0] {
      S_CLEAR    = 8'b0000_0001,
      S_IDLE     = 8'b0000_0010,
      S_INS      = 8'b0000_0100,
      S_INS_LINK = 8'b0000_1000,
      S_DEL_CHK  = 8'b0001_0000,
      S_DEL_LINK = 8'b0010_0000,
      S_SRCH     = 8'b0100_0000,
      S_REPLY    = 8'b1000_0000
   } state_type;

   function automatic logic is_slot(input logic [LW-1:0] link);
      is_slot = (link < LW'(SLOT_COUNT));
   endfunction

   state_type                 state_ff, state_in;
   logic [LW-1:0]             list_head_ff, list_head_in;
   logic [LW-1:0]             free_head_ff, free_head_in;
   logic [SW-1:0]             clr_ff, clr_in;
   logic [SW-1:0]             cur_ff, cur_in;
   logic [SW:0]               steps_ff, steps_in;
   logic [LW-1:0]             nx_ff, nx_in;
   logic [LW-1:0]             pv_ff, pv_in;
   logic [KW-1:0]             key_ff, key_in;
   alle_pkg::status_type      res_status_ff, res_status_in;
   logic [SW-1:0]             res_slot_ff, res_slot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   alle_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [RSW-1:0]            rsp_slot_ff, rsp_slot_in;

   // memory read fields
   logic                      a_in_use;
   logic [LW-1:0]             a_next;
   logic [KW-1:0]             b_key;
   logic [LW-1:0]             b_prev;
   logic [SW-1:0]             idx_addr;

   assign a_in_use = a_rd_data[LW];
   assign a_next   = a_rd_data[LW-1:0];
   assign b_key    = b_rd_data[KW+LW-1:LW];
   assign b_prev   = b_rd_data[LW-1:0];
   assign idx_addr = SW'(req_slot_index);

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;

   // Next-state and memory access logic
   always_comb begin
      state_in      = state_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      nx_in         = nx_ff;
      pv_in         = pv_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      a_wr_en       = 1'b0;
      a_wr_addr     = cur_ff;
      a_wr_data     = '0;
      a_rd_en       = 1'b0;
      a_rd_addr     = cur_ff;
      b_wr_en       = 1'b0;
      b_wr_addr     = cur_ff;
      b_wr_data     = '0;
      b_rd_en       = 1'b0;
      b_rd_addr     = cur_ff;

      unique case (state_ff)
         // Build the free chain after reset, one entry a cycle
         S_CLEAR: begin
            a_wr_en   = 1'b1;
            a_wr_addr = clr_ff;
            if (clr_ff == SW'(SLOT_COUNT - 1)) begin
               a_wr_data = {1'b0, NIL};
               state_in  = S_IDLE;
            end else begin
               a_wr_data = {1'b0, LW'(clr_ff) + LW'(1)};
            end
            clr_in = clr_ff + SW'(1);
         end

         // Dispatch: issue the first reads or answer at once
         S_IDLE: begin
            if (req_valid) begin
               key_in = req_key_value;
               case (req_opcode)
                  alle_pkg::OP_INSERT: begin
                     if (!is_slot(free_head_ff)) begin
                        res_status_in = alle_pkg::ST_FULL;
                        state_in      = S_REPLY;
                     end else begin
                        a_rd_en   = 1'b1;
                        a_rd_addr = free_head_ff[SW-1:0];
                        b_rd_en   = is_slot(list_head_ff);
                        b_rd_addr = list_head_ff[SW-1:0];
                        cur_in    = free_head_ff[SW-1:0];
                        state_in  = S_INS;
                     end
                  end
                  alle_pkg::OP_DELETE: begin
                     if (32'(req_slot_index) >= SLOT_COUNT) begin
                        res_status_in = alle_pkg::ST_NOT_FOUND;
                        state_in      = S_REPLY;
                     end else begin
                        a_rd_en   = 1'b1;
                        a_rd_addr = idx_addr;
                        b_rd_en   = 1'b1;
                        b_rd_addr = idx_addr;
                        cur_in    = idx_addr;
                        state_in  = S_DEL_CHK;
                     end
                  end
                  alle_pkg::OP_SEARCH: begin
                     if (!is_slot(list_head_ff)) begin
                        res_status_in = alle_pkg::ST_NOT_FOUND;
                        state_in      = S_REPLY;
                     end else begin
                        a_rd_en   = 1'b1;
                        a_rd_addr = list_head_ff[SW-1:0];
                        b_rd_en   = 1'b1;
                        b_rd_addr = list_head_ff[SW-1:0];
                        cur_in    = list_head_ff[SW-1:0];
                        steps_in  = (SW+1)'(1);
                        state_in  = S_SRCH;
                     end
                  end
                  default: begin
                     res_status_in = alle_pkg::ST_NOT_FOUND;
                     state_in      = S_REPLY;
                  end
               endcase
            end
         end

         // Insert: pop the free slot, fill it, link it before the old head
         S_INS: begin
            free_head_in = a_next;
            a_wr_en      = 1'b1;
            a_wr_data    = {1'b1, list_head_ff};
            b_wr_en      = 1'b1;
            b_wr_data    = {key_ff, NIL};
            res_status_in = alle_pkg::ST_OK;
            res_slot_in   = cur_ff;
            if (is_slot(list_head_ff)) begin
               state_in = S_INS_LINK;
            end else begin
               list_head_in = LW'(cur_ff);
               state_in     = S_REPLY;
            end
         end

         // Insert: old head gets the new slot as its prev, key kept
         S_INS_LINK: begin
            b_wr_en      = 1'b1;
            b_wr_addr    = list_head_ff[SW-1:0];
            b_wr_data    = {b_key, LW'(cur_ff)};
            list_head_in = LW'(cur_ff);
            state_in     = S_REPLY;
         end

         // Delete: check the slot, push it on the free list, fetch its successor
         S_DEL_CHK: begin
            if (!a_in_use) begin
               res_status_in = alle_pkg::ST_NOT_FOUND;
               state_in      = S_REPLY;
            end else begin
               nx_in        = a_next;
               pv_in        = b_prev;
               a_wr_en      = 1'b1;
               a_wr_data    = {1'b0, free_head_ff};
               free_head_in = LW'(cur_ff);
               b_rd_en      = is_slot(a_next);
               b_rd_addr    = a_next[SW-1:0];
               state_in     = S_DEL_LINK;
            end
         end

         // Delete: splice neighbors around the removed slot
         S_DEL_LINK: begin
            if (is_slot(pv_ff)) begin
               a_wr_en   = 1'b1;
               a_wr_addr = pv_ff[SW-1:0];
               a_wr_data = {1'b1, nx_ff};
            end else begin
               list_head_in = nx_ff;
            end
            if (is_slot(nx_ff)) begin
               b_wr_en   = 1'b1;
               b_wr_addr = nx_ff[SW-1:0];
               b_wr_data = {b_key, pv_ff};
            end
            res_status_in = alle_pkg::ST_OK;
            res_slot_in   = cur_ff;
            state_in      = S_REPLY;
         end

         // Search: compare one slot per cycle, follow next
         S_SRCH: begin
            if (b_key == key_ff) begin
               res_status_in = alle_pkg::ST_OK;
               res_slot_in   = cur_ff;
               state_in      = S_REPLY;
            end else if ((steps_ff == (SW+1)'(SLOT_COUNT)) || !is_slot(a_next)) begin
               res_status_in = alle_pkg::ST_NOT_FOUND;
               state_in      = S_REPLY;
            end else begin
               a_rd_en   = 1'b1;
               a_rd_addr = a_next[SW-1:0];
               b_rd_en   = 1'b1;
               b_rd_addr = a_next[SW-1:0];
               cur_in    = a_next[SW-1:0];
               steps_in  = steps_ff + (SW+1)'(1);
            end
         end

         // Hand the result to the output register once it is free
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = (res_status_ff == alle_pkg::ST_OK) ? RSW'(res_slot_ff) : '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         list_head_ff <= NIL;
         free_head_ff <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      nx_ff         <= nx_in;
      pv_ff         <= pv_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // A slot is never both the list head and the free head, except while a
   // deleted head slot is being spliced out
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_DEL_LINK && is_slot(list_head_ff) && is_slot(free_head_ff)
         |-> list_head_ff != free_head_ff)
      else $error("list head and free head name the same slot");

   // A full answer is only given when no slot is free
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REPLY && res_status_ff == alle_pkg::ST_FULL |-> !is_slot(free_head_ff))
      else $error("full reported with a free slot");

   // Error responses carry slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != alle_pkg::ST_OK |-> rsp_result_slot == '0)
      else $error("nonzero slot on error response");

   // Only defined status codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == alle_pkg::ST_OK || rsp_status == alle_pkg::ST_FULL ||
                    rsp_status == alle_pkg::ST_NOT_FOUND)
      else $error("undefined status code");

   // Deleted slot is pushed on the free list
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEL_LINK |-> free_head_ff == LW'(cur_ff))
      else $error("deleted slot not at free head");

endmodule

`default_nettype wire
